// ===== rtl/core/mmt_pkg.sv =====
package mmt_pkg;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] element;
   } req_type;

   typedef struct packed {
      logic signed [31:0] product;
      logic [2:0]         row;
      logic [2:0]         col;
      logic               saturated;
      logic               last;
   } rsp_type;

   localparam logic OP_LOAD_A = 1'b0;
   localparam logic OP_LOAD_B = 1'b1;

   localparam logic [2:0] REG_ROWS_A      = 3'd0;
   localparam logic [2:0] REG_INNER_SIZE  = 3'd1;
   localparam logic [2:0] REG_COLS_B      = 3'd2;
   localparam logic [2:0] REG_TRANSPOSE_A = 3'd3;
   localparam logic [2:0] REG_TRANSPOSE_B = 3'd4;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FETCH,
      ST_DRAIN,
      ST_OUT
   } state_type;

   // control handed along the cell chain
   typedef struct packed {
      logic start;
      logic valid;
   } cell_ctl_type;

endpackage

// ===== rtl/core/mmt_cell.sv =====
// One multiply-accumulate cell: registers the product of its operand pair,
// adds it into the partial sum arriving from the previous cell, and hands the
// sum to the next cell.
module mmt_cell #(
   parameter int ELEM_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mmt_pkg::cell_ctl_type             ctl_in,
   input  logic signed [ELEM_WIDTH-1:0]      a_in,
   input  logic signed [ELEM_WIDTH-1:0]      b_in,
   input  logic signed [2*ELEM_WIDTH+3:0]    sum_in,
   output mmt_pkg::cell_ctl_type             ctl_out,
   output logic signed [2*ELEM_WIDTH+3:0]    sum_out
);
   import mmt_pkg::*;

   localparam int AccW = 2 * ELEM_WIDTH + 4;

   cell_ctl_type                 ctl_ff;
   logic signed [2*ELEM_WIDTH-1:0] prod_ff;
   logic signed [AccW-1:0]       sum_ff, sum_hold_ff;

   // stage one: multiply, pass the incoming sum alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      prod_ff     <= a_in * b_in;
      sum_hold_ff <= sum_in;
   end

   // stage two: accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_out <= '0;
      end else begin
         ctl_out <= ctl_ff;
      end
      sum_ff <= sum_hold_ff + AccW'(prod_ff);
   end

   assign sum_out = sum_ff;

endmodule

// ===== rtl/core/mmt_round.sv =====
// Rounds the exact sum back to the element format and saturates it.
module mmt_round #(
   parameter int ELEM_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           valid_in,
   input  logic signed [2*ELEM_WIDTH+3:0] sum_in,
   output logic                           valid_out,
   output logic signed [ELEM_WIDTH-1:0]   value_out,
   output logic                           sat_out
);
   import mmt_pkg::*;

   localparam int AccW = 2 * ELEM_WIDTH + 4;
   localparam int FracBits = ELEM_WIDTH / 2;
   localparam int ShW = AccW - FracBits;

   logic signed [AccW-1:0]       rnd;
   logic signed [ShW-1:0]        shifted;
   logic signed [ShW-1:0]        max_v, min_v;
   logic                         valid_ff;
   logic signed [ELEM_WIDTH-1:0] value_ff;
   logic                         sat_ff;

   always_comb begin
      rnd     = sum_in + (AccW'(1) <<< (FracBits - 1));
      shifted = rnd[AccW-1:FracBits];
      max_v   = ShW'({1'b0, {(ELEM_WIDTH-1){1'b1}}});
      min_v   = -max_v - ShW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (shifted > max_v) begin
         value_ff <= {1'b0, {(ELEM_WIDTH-1){1'b1}}};
         sat_ff   <= 1'b1;
      end else if (shifted < min_v) begin
         value_ff <= {1'b1, {(ELEM_WIDTH-1){1'b0}}};
         sat_ff   <= 1'b1;
      end else begin
         value_ff <= shifted[ELEM_WIDTH-1:0];
         sat_ff   <= 1'b0;
      end
   end

   assign valid_out = valid_ff;
   assign value_out = value_ff;
   assign sat_out   = sat_ff;

endmodule

// ===== rtl/core/matrix_multiply_transpose.sv =====
// Loading: one request transaction per cycle; requests wait while a product is in
// progress. The transaction that completes both matrices starts the product: per
// product element, inner_size operand pairs are fetched one per cycle, overlapped
// with a head register, MAX_DIM two-stage cells, the rounding stage and the
// response register. Elements are computed one at a time; the next element's fetch
// starts once the previous response is taken. Reset: sizes 1, flags and counts 0, stores undefined.
module matrix_multiply_transpose #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mmt_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mmt_pkg::rsp_type     rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata
);
   import mmt_pkg::*;

   localparam int Depth = MAX_DIM * MAX_DIM;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);
   localparam int DimW  = $clog2(MAX_DIM + 1);
   localparam int IdxW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int AccW  = 2 * ELEM_WIDTH + 4;

   // configuration registers
   logic [3:0] rows_a_ff, inner_ff, cols_b_ff;
   logic       tr_a_ff, tr_b_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= 4'd1;
         inner_ff  <= 4'd1;
         cols_b_ff <= 4'd1;
         tr_a_ff   <= 1'b0;
         tr_b_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ROWS_A:      rows_a_ff <= csr_wdata[3:0];
            REG_INNER_SIZE:  inner_ff  <= csr_wdata[3:0];
            REG_COLS_B:      cols_b_ff <= csr_wdata[3:0];
            REG_TRANSPOSE_A: tr_a_ff   <= csr_wdata[0];
            REG_TRANSPOSE_B: tr_b_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective dimensions, clamped to 1..MAX_DIM
   function automatic logic [DimW-1:0] eff_dim(input logic [3:0] v);
      logic [DimW-1:0] r;
      if (v == 4'd0) r = DimW'(1);
      else if (32'(v) > MAX_DIM) r = DimW'(MAX_DIM);
      else r = DimW'(v);
      return r;
   endfunction

   logic [DimW-1:0] nr, nk, nc;
   logic [CntW-1:0] na, nb;
   assign nr = eff_dim(rows_a_ff);
   assign nk = eff_dim(inner_ff);
   assign nc = eff_dim(cols_b_ff);
   assign na = CntW'(nr) * CntW'(nk);
   assign nb = CntW'(nk) * CntW'(nc);

   // element memories
   logic [ELEM_WIDTH-1:0] a_mem [Depth];
   logic [ELEM_WIDTH-1:0] b_mem [Depth];
   logic [ELEM_WIDTH-1:0] a_rd_ff, b_rd_ff;
   logic [AddrW-1:0]      a_addr, b_addr;

   logic [CntW-1:0] a_cnt_ff, a_cnt_in, b_cnt_ff, b_cnt_in;
   state_type       state_ff, state_in;
   logic [IdxW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic            fetch_vld_ff, fetch_vld_in, fetch_start_ff, fetch_start_in;
   logic            res_vld;
   logic [ELEM_WIDTH-1:0] res_val;
   logic            res_sat;
   rsp_type         rsp_ff, rsp_in;
   logic            wr_a, wr_b;

   assign wr_a = req_valid && req_ready && req_data.opcode == OP_LOAD_A && a_cnt_ff < na;
   assign wr_b = req_valid && req_ready && req_data.opcode == OP_LOAD_B && b_cnt_ff < nb;

   always_ff @(posedge clock) begin
      if (wr_a) a_mem[a_cnt_ff[AddrW-1:0]] <= req_data.element[ELEM_WIDTH-1:0];
      if (wr_b) b_mem[b_cnt_ff[AddrW-1:0]] <= req_data.element[ELEM_WIDTH-1:0];
      a_rd_ff <= a_mem[a_addr];
      b_rd_ff <= b_mem[b_addr];
   end

   // operand addresses for the current (i, j, k)
   always_comb begin
      if (tr_a_ff) a_addr = AddrW'(32'(i_ff) + 32'(nr) * 32'(k_ff));
      else         a_addr = AddrW'(32'(k_ff) + 32'(nk) * 32'(i_ff));
      if (tr_b_ff) b_addr = AddrW'(32'(k_ff) + 32'(nk) * 32'(j_ff));
      else         b_addr = AddrW'(32'(j_ff) + 32'(nc) * 32'(k_ff));
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      a_cnt_in       = a_cnt_ff;
      b_cnt_in       = b_cnt_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      k_in           = k_ff;
      fetch_vld_in   = 1'b0;
      fetch_start_in = 1'b0;
      rsp_in         = rsp_ff;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (wr_a) a_cnt_in = a_cnt_ff + CntW'(1);
            if (wr_b) b_cnt_in = b_cnt_ff + CntW'(1);
            if (req_valid && a_cnt_in >= na && b_cnt_in >= nb) begin
               state_in = ST_FETCH;
               i_in = '0;
               j_in = '0;
               k_in = '0;
            end
         end
         ST_FETCH: begin
            fetch_vld_in   = 1'b1;
            fetch_start_in = (k_ff == '0);
            if (32'(k_ff) + 1 >= 32'(nk)) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + IdxW'(1);
            end
         end
         ST_DRAIN: begin
            if (res_vld) begin
               rsp_in.product   = 32'(signed'(res_val));
               rsp_in.row       = 3'(i_ff);
               rsp_in.col       = 3'(j_ff);
               rsp_in.saturated = res_sat;
               rsp_in.last      = (32'(i_ff) + 1 == 32'(nr)) && (32'(j_ff) + 1 == 32'(nc));
               state_in         = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               k_in = '0;
               if (rsp_ff.last) begin
                  state_in = ST_LOAD;
                  a_cnt_in = '0;
                  b_cnt_in = '0;
               end else begin
                  state_in = ST_FETCH;
                  if (32'(j_ff) + 1 == 32'(nc)) begin
                     j_in = '0;
                     i_in = i_ff + IdxW'(1);
                  end else begin
                     j_in = j_ff + IdxW'(1);
                  end
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         a_cnt_ff       <= '0;
         b_cnt_ff       <= '0;
         fetch_vld_ff   <= 1'b0;
         fetch_start_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         a_cnt_ff       <= a_cnt_in;
         b_cnt_ff       <= b_cnt_in;
         fetch_vld_ff   <= fetch_vld_in;
         fetch_start_ff <= fetch_start_in;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;

   // chain of cells: the sum enters at cell 0 and moves from cell to cell;
   // operands are delayed per cell so that term k meets the sum at
   // cell k.
   cell_ctl_type             ctl_c [MAX_DIM+1];
   logic signed [AccW-1:0]   sum_c [MAX_DIM+1];
   logic signed [ELEM_WIDTH-1:0] a_d [MAX_DIM];
   logic signed [ELEM_WIDTH-1:0] b_d [MAX_DIM];
   logic [MAX_DIM-1:0]       term_vld_d;
   logic                     head_vld_ff;

   // operand delay line: term number k must reach cell k together with the sum
   // from cell k-1; back-to-back fetches plus a tap per cell give the needed skew,
   // so operands hop one tap per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         term_vld_d  <= '0;
         head_vld_ff <= 1'b0;
      end else begin
         term_vld_d  <= {term_vld_d[MAX_DIM-2+((MAX_DIM>1)?0:1):0], fetch_vld_ff};
         head_vld_ff <= fetch_vld_ff && fetch_start_ff;
      end
      a_d[0] <= a_rd_ff;
      b_d[0] <= b_rd_ff;
      for (int d = 1; d < MAX_DIM; d++) begin
         a_d[d] <= a_d[d-1];
         b_d[d] <= b_d[d-1];
      end
   end

   // cell d takes fetch k=d; the fetch order and the taps line term k up with the
   // sum as it reaches cell k.
   assign ctl_c[0].start = head_vld_ff;
   assign ctl_c[0].valid = head_vld_ff;
   assign sum_c[0]       = '0;

   for (genvar d = 0; d < MAX_DIM; d++) begin : g_cell
      logic use_term;
      logic signed [ELEM_WIDTH-1:0] a_op, b_op;
      assign use_term = (d < 32'(nk)) && term_vld_d[d] && ctl_c[d].valid;
      assign a_op = use_term ? a_d[d] : '0;
      assign b_op = use_term ? b_d[d] : '0;
      mmt_cell #(.ELEM_WIDTH(ELEM_WIDTH)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (ctl_c[d]),
         .a_in    (a_op),
         .b_in    (b_op),
         .sum_in  (sum_c[d]),
         .ctl_out (ctl_c[d+1]),
         .sum_out (sum_c[d+1])
      );
   end

   mmt_round #(.ELEM_WIDTH(ELEM_WIDTH)) u_round (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (ctl_c[MAX_DIM].valid),
      .sum_in    (sum_c[MAX_DIM]),
      .valid_out (res_vld),
      .value_out (res_val),
      .sat_out   (res_sat)
   );

endmodule

// ===== sim/mmt_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, response and register channels, keeps its own copy of
// the matrix stores and register file, and checks every response in order.
module mmt_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  mmt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  mmt_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output int               error_count,
   output int               pending_count
);
   import mmt_pkg::*;

   localparam int DIM_LIMIT = 8;

   logic [3:0]  rows_reg, inner_reg, cols_reg;
   logic        trans_a_reg, trans_b_reg;
   logic [31:0] a_mem [64];
   logic [31:0] b_mem [64];
   int          a_count, b_count;
   rsp_type     product_queue [$];

   assign pending_count = product_queue.size();

   // size register as the block uses it: 0 acts as 1, above the limit clamps
   function automatic int clamp_dim(logic [3:0] v);
      if (v == 0) return 1;
      if (v > DIM_LIMIT) return DIM_LIMIT;
      return int'(v);
   endfunction

   // one product element: exact sum, round half up, saturate to 32 bits
   task automatic push_product_element(int i, int j, int nr, int nk, int nc);
      logic signed [127:0] acc;
      logic signed [127:0] rounded;
      logic signed [31:0]  a_val, b_val;
      logic signed [63:0]  prod;
      rsp_type             elem;
      int                  ia, ib;
      acc = '0;
      for (int k = 0; k < nk; k++) begin
         ia = trans_a_reg ? (i + nr * k) : (k + nk * i);
         ib = trans_b_reg ? (k + nk * j) : (j + nc * k);
         a_val = a_mem[ia];
         b_val = b_mem[ib];
         prod = a_val * b_val;
         acc = acc + prod;
      end
      rounded = (acc + 128'sd32768) >>> 16;
      elem.saturated = 1'b0;
      if (rounded > 128'sd2147483647) begin
         elem.product   = 32'h7fff_ffff;
         elem.saturated = 1'b1;
      end else if (rounded < -128'sd2147483648) begin
         elem.product   = 32'h8000_0000;
         elem.saturated = 1'b1;
      end else begin
         elem.product = rounded[31:0];
      end
      elem.row  = i[2:0];
      elem.col  = j[2:0];
      elem.last = (i == nr - 1) && (j == nc - 1);
      product_queue.push_back(elem);
   endtask

   always @(posedge clock) begin
      int nr, nk, nc;
      rsp_type exp_rsp;
      if (reset) begin
         rows_reg    <= 4'd1;
         inner_reg   <= 4'd1;
         cols_reg    <= 4'd1;
         trans_a_reg <= 1'b0;
         trans_b_reg <= 1'b0;
         a_count     = 0;
         b_count     = 0;
         error_count <= 0;
         product_queue.delete();
      end else begin
         // register write
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ROWS_A:      rows_reg    <= csr_wdata[3:0];
               REG_INNER_SIZE:  inner_reg   <= csr_wdata[3:0];
               REG_COLS_B:      cols_reg    <= csr_wdata[3:0];
               REG_TRANSPOSE_A: trans_a_reg <= csr_wdata[0];
               REG_TRANSPOSE_B: trans_b_reg <= csr_wdata[0];
               default: ;
            endcase
         end

         // element load; the completing transaction yields the whole product
         if (req_valid && req_ready) begin
            nr = clamp_dim(rows_reg);
            nk = clamp_dim(inner_reg);
            nc = clamp_dim(cols_reg);
            if (req_data.opcode == OP_LOAD_A) begin
               if (a_count < nr * nk) begin
                  a_mem[a_count] = req_data.element;
                  a_count++;
               end
            end else begin
               if (b_count < nk * nc) begin
                  b_mem[b_count] = req_data.element;
                  b_count++;
               end
            end
            if (a_count >= nr * nk && b_count >= nk * nc) begin
               for (int i = 0; i < nr; i++)
                  for (int j = 0; j < nc; j++)
                     push_product_element(i, j, nr, nk, nc);
               a_count = 0;
               b_count = 0;
            end
         end

         // response check against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (product_queue.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               error_count <= error_count + 1;
            end else begin
               exp_rsp = product_queue.pop_front();
               if (rsp_data !== exp_rsp) begin
                  $display("%0t: mismatch expected %p actual %p", $time, exp_rsp, rsp_data);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== sim/tb_matrix_multiply_transpose.sv =====
`timescale 1ns / 1ps

module tb_matrix_multiply_transpose;
   import mmt_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 120;

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready;
   req_type     req_data;
   logic        rsp_valid, rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   int          error_count, pending_count;

   logic        req_taken, csr_taken;
   int          idle_cycles;
   int          burst_left;
   int          hold_requests, hold_served;
   int          items_sent;

   matrix_multiply_transpose i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mmt_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // handshakes as seen at the rising edge, read by the drivers at the falling edge
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      csr_taken <= csr_valid && csr_ready;
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("matrix_multiply_transpose test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stall modes, plus a long hold-off on request
   initial begin
      int mode, mode_left, hold_left;
      rsp_ready = 1'b0;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            case (mode)
               0:       rsp_ready = 1'b1;
               1:       rsp_ready = ($urandom_range(0, 1) == 0);
               2:       rsp_ready = ($urandom_range(0, 3) == 0);
               default: rsp_ready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // one request transaction; valid stays up within a burst
   task automatic send_element(logic op, logic [31:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid = 1'b1;
      req_data.opcode  = op;
      req_data.element = value;
      do @(negedge clock); while (!req_taken);
      req_valid = 1'b0;
      items_sent++;
   endtask

   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = value;
      do @(negedge clock); while (!csr_taken);
      csr_valid = 1'b0;
   endtask

   // all results in, then let the datapath settle before touching registers
   task automatic wait_quiet();
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_shape(logic [3:0] nr, logic [3:0] nk, logic [3:0] nc,
                            logic ta, logic tb);
      write_reg(REG_ROWS_A, {20'd0, 8'($urandom_range(0, 255)), nr});
      write_reg(REG_INNER_SIZE, {28'd0, nk});
      write_reg(REG_COLS_B, {28'd0, nc});
      write_reg(REG_TRANSPOSE_A, {31'd0, ta});
      write_reg(REG_TRANSPOSE_B, {31'd0, tb});
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
         3, 4:    return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic int eff_size(logic [3:0] v);
      if (v == 0) return 1;
      if (v > 8) return 8;
      return int'(v);
   endfunction

   // one full product in random interleaved order, with some dropped extras
   task automatic send_product(int na, int nb);
      int a_left, b_left;
      a_left = na;
      b_left = nb;
      while (a_left + b_left > 0) begin
         if ($urandom_range(0, 19) == 0 && (a_left == 0 || b_left == 0) && a_left + b_left > 1)
            send_element(a_left == 0 ? OP_LOAD_A : OP_LOAD_B, pick_value());
         if (b_left == 0 || (a_left > 0 && $urandom_range(0, 1) == 0)) begin
            send_element(OP_LOAD_A, pick_value());
            a_left--;
         end else begin
            send_element(OP_LOAD_B, pick_value());
            b_left--;
         end
      end
   endtask

   initial begin
      logic [3:0] nr, nk, nc;
      int         reps;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = REG_ROWS_A;
      csr_wdata = '0;
      burst_left = 0;
      hold_requests = 0;
      hold_served = 0;
      items_sent = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // reset shape 1x1x1: saturation both ways, rounding, dropped extra element
      send_element(OP_LOAD_A, 32'h7fff_ffff);
      send_element(OP_LOAD_B, 32'h7fff_ffff);
      send_element(OP_LOAD_A, 32'h8000_0000);
      send_element(OP_LOAD_B, 32'h8000_0000);
      send_element(OP_LOAD_B, 32'h7fff_ffff);
      send_element(OP_LOAD_A, 32'h8000_0000);
      send_element(OP_LOAD_A, 32'hffff_ffff);
      send_element(OP_LOAD_A, 32'h1234_5678);
      send_element(OP_LOAD_B, 32'h0000_0001);
      send_element(OP_LOAD_A, 32'h0000_8000);
      send_element(OP_LOAD_B, 32'h0000_0001);
      send_element(OP_LOAD_A, 32'h0000_0000);
      send_element(OP_LOAD_B, 32'hffff_ffff);
      wait_quiet();

      // size zero acts as one, oversized acts as the maximum
      set_shape(4'd0, 4'd2, 4'd15, 1'b1, 1'b0);
      send_element(OP_LOAD_A, 32'h0001_0000);
      send_element(OP_LOAD_A, 32'hfffe_0000);
      send_element(OP_LOAD_B, 32'h7fff_ffff);
      wait_quiet();
      // shape changed while loading: counts carry over
      set_shape(4'd2, 4'd2, 4'd1, 1'b0, 1'b1);
      send_element(OP_LOAD_A, 32'h8000_0000);
      send_element(OP_LOAD_A, 32'h0003_0000);
      send_element(OP_LOAD_B, 32'h8000_0000);
      send_element(OP_LOAD_B, 32'h0000_c000);
      send_element(OP_LOAD_A, 32'hffff_8000);
      send_element(OP_LOAD_A, 32'h0000_4000);
      wait_quiet();

      // long receiver hold-off while products keep coming in
      set_shape(4'd3, 4'd2, 4'd4, 1'b1, 1'b1);
      hold_requests++;
      send_product(6, 8);
      send_product(6, 8);
      send_product(6, 8);
      wait_quiet();

      // random shapes; the first two are the extremes
      reps = 0;
      while (items_sent < 230) begin
         if (reps == 0) begin
            nr = 4'd8; nk = 4'd8; nc = 4'd8;
         end else if (reps == 1) begin
            nr = 4'd1; nk = 4'd1; nc = 4'd1;
         end else if ($urandom_range(0, 9) == 0) begin
            nr = 4'($urandom); nk = 4'($urandom); nc = 4'($urandom);
         end else begin
            nr = 4'($urandom_range(1, 4));
            nk = 4'($urandom_range(1, 4));
            nc = 4'($urandom_range(1, 4));
         end
         set_shape(nr, nk, nc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         repeat ((reps < 2) ? 1 : $urandom_range(1, 3))
            send_product(eff_size(nr) * eff_size(nk), eff_size(nk) * eff_size(nc));
         // occasional stray elements leave a partial load across the next write
         if ($urandom_range(0, 4) == 0)
            send_element(1'($urandom_range(0, 1)), pick_value());
         wait_quiet();
         reps++;
      end

      wait_quiet();
      if (error_count == 0 && pending_count == 0) begin
         $display("matrix_multiply_transpose test passed");
      end else begin
         $display("matrix_multiply_transpose test failed");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/mmt_pkg.sv
rtl/core/mmt_cell.sv
rtl/core/mmt_round.sv
rtl/core/matrix_multiply_transpose.sv
sim/mmt_checker.sv
sim/tb_matrix_multiply_transpose.sv
